[rtl/core/mhtq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_pkg
// Shared types, codes and default sizes of the min-heap timer queue.
// ----------------------------------------------------------------------------
package mhtq_pkg;

    localparam int HEAP_DEPTH_DEF = 32;
    localparam int ID_COUNT_DEF   = 256;

    localparam int ID_W    = 8;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 6;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_FIRED     = 3'd3,
        ST_DROPPED   = 3'd4,
        ST_DONE      = 3'd5
    } t_status;

    // One heap slot: expiry key and timer id
    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [ID_W-1:0]   ident;
    } t_entry;

endpackage

[rtl/core/mhtq_heap_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_heap_mem
// Heap slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mhtq_heap_mem #(
    parameter int DEPTH = mhtq_pkg::HEAP_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  mhtq_pkg::t_entry i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output mhtq_pkg::t_entry o_rdata
);

    mhtq_pkg::t_entry r_mem [DEPTH];
    mhtq_pkg::t_entry r_rdata;

    // Write and read the slot array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mhtq_flag_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_flag_mem
// Cancel flag store: one bit per timer id, registered read data.
// ----------------------------------------------------------------------------
module mhtq_flag_mem #(
    parameter int DEPTH = mhtq_pkg::ID_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    // Write and read the flag array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/min_heap_timer_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_timer_queue
// Binary min-heap of timers keyed by expiry, with lazy cancel by id.
// ----------------------------------------------------------------------------
// Usage: one input channel (i_in_valid / o_in_stall) takes insert, cancel
// and tick items; one output channel (o_out_valid / i_out_stall) returns
// result items, o_last marking the final result of each input item.
// Items are processed one at a time; o_in_stall stays high while an item
// is at work. Insert and cancel give one result; a tick gives one result
// per popped root and then a done result. Kind 3 is dropped silently.
// An insert climbs the heap one level at a time, reading the parent and
// comparing; each pop sifts down level by level, with up to two child reads
// through the single heap read port, then a compare.
// Reset: the heap empties at once; then a clearing pass over all ID_COUNT
// flags zeroes the cancel flag store, during which o_in_stall is held high.
// A stalled receiver holds the output register; the next result waits in
// the sequencer, and a new input item is taken once the current one ends.
// ----------------------------------------------------------------------------
module min_heap_timer_queue #(
    parameter int HEAP_DEPTH = mhtq_pkg::HEAP_DEPTH_DEF,
    parameter int ID_COUNT   = mhtq_pkg::ID_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mhtq_pkg::KIND_W-1:0]   i_kind,
    input  logic [mhtq_pkg::ID_W-1:0]     i_timer_id,
    input  logic [mhtq_pkg::TIME_W-1:0]   i_expire_time,
    input  logic [mhtq_pkg::TIME_W-1:0]   i_now_time,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mhtq_pkg::STAT_W-1:0]   o_status,
    output logic [mhtq_pkg::ID_W-1:0]     o_out_id,
    output logic [mhtq_pkg::TIME_W-1:0]   o_out_expire,
    output logic [mhtq_pkg::COUNT_W-1:0]  o_entry_count,
    output logic [mhtq_pkg::TIME_W-1:0]   o_next_expire,
    output logic                          o_last
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int FW = $clog2(ID_COUNT);
    localparam int XW = AW + 2;
    localparam int NID = 1 << mhtq_pkg::ID_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INS,
        S_INS_CMP,
        S_TICK,
        S_POP,
        S_SD,
        S_SD_C1,
        S_SD_C2,
        S_SD_CMP,
        S_EMIT
    } t_state;

    t_state                          r_state;
    t_state                          r_ret;
    logic [FW-1:0]                   r_clr_addr;
    logic [CW-1:0]                   r_count;
    mhtq_pkg::t_entry                r_root;
    mhtq_pkg::t_entry                r_key;
    mhtq_pkg::t_entry                r_best;
    logic [AW-1:0]                   r_best_idx;
    logic [AW-1:0]                   r_pos;
    logic [mhtq_pkg::TIME_W-1:0]     r_now;
    mhtq_pkg::t_status               r_res_status;
    logic [mhtq_pkg::ID_W-1:0]       r_res_id;
    logic [mhtq_pkg::TIME_W-1:0]     r_res_exp;
    logic                            r_res_last;
    logic                            r_out_valid;
    logic [mhtq_pkg::STAT_W-1:0]     r_out_status;
    logic [mhtq_pkg::ID_W-1:0]       r_out_id;
    logic [mhtq_pkg::TIME_W-1:0]     r_out_exp;
    logic [mhtq_pkg::COUNT_W-1:0]    r_out_count;
    logic [mhtq_pkg::TIME_W-1:0]     r_out_next;
    logic                            r_out_last;

    logic                            w_accept;
    logic                            w_out_free;
    logic [FW-1:0]                   w_mod_tab [NID];
    logic [AW-1:0]                   w_parent;
    logic [AW:0]                     w_c1;
    logic [AW:0]                     w_c2;
    logic                            w_has_c1;
    logic                            w_has_c2;
    logic                            w_full;
    logic                            w_best_lt;
    logic                            w_par_le;

    logic                            w_hwe;
    logic [AW-1:0]                   w_hwaddr;
    mhtq_pkg::t_entry                w_hwdata;
    logic [AW-1:0]                   w_hraddr;
    mhtq_pkg::t_entry                w_hrdata;

    logic                            w_fwe;
    logic [FW-1:0]                   w_fwaddr;
    logic                            w_fwdata;
    logic                            w_frdata;

    // Fold id into the flag range; constant table worked out at elaboration
    for (genvar gi = 0; gi < NID; gi++) begin : g_mod
        assign w_mod_tab[gi] = FW'(gi % ID_COUNT);
    end

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_parent   = AW'((r_pos - AW'(1)) >> 1);
    assign w_c1       = {r_pos, 1'b1};
    assign w_c2       = w_c1 + (AW + 1)'(1);
    assign w_has_c1   = XW'(w_c1) < XW'(r_count);
    assign w_has_c2   = XW'(w_c2) < XW'(r_count);
    assign w_full     = r_count >= CW'(HEAP_DEPTH);
    assign w_best_lt  = r_best.expiry < r_key.expiry;
    assign w_par_le   = w_hrdata.expiry <= r_key.expiry;

    // Drive heap memory ports from the sequencer state
    always_comb begin
        w_hwe    = 1'b0;
        w_hwaddr = r_pos;
        w_hwdata = r_key;
        w_hraddr = '0;
        case (r_state)
            S_INS: begin
                if (r_pos == '0) begin
                    w_hwe = 1'b1;
                end else begin
                    w_hraddr = w_parent;
                end
            end
            S_INS_CMP: begin
                w_hwe    = 1'b1;
                w_hwdata = w_par_le ? r_key : w_hrdata;
            end
            S_TICK: begin
                w_hraddr = AW'(r_count - CW'(1));
            end
            S_SD: begin
                if (w_has_c1) begin
                    w_hraddr = w_c1[AW-1:0];
                end else begin
                    w_hwe = 1'b1;
                end
            end
            S_SD_C1: begin
                w_hraddr = w_c2[AW-1:0];
            end
            S_SD_CMP: begin
                w_hwe    = 1'b1;
                w_hwdata = w_best_lt ? r_best : r_key;
            end
            default: begin
                w_hwe = 1'b0;
            end
        endcase
    end

    // Drive flag memory ports: clearing sweep, then insert and cancel writes
    always_comb begin
        w_fwe    = 1'b0;
        w_fwaddr = w_mod_tab[i_timer_id];
        w_fwdata = 1'b0;
        if (r_state == S_CLEAR) begin
            w_fwe    = 1'b1;
            w_fwaddr = r_clr_addr;
        end else if (w_accept) begin
            if (i_kind == mhtq_pkg::KIND_INSERT && !w_full) begin
                w_fwe = 1'b1;
            end else if (i_kind == mhtq_pkg::KIND_CANCEL) begin
                w_fwe    = 1'b1;
                w_fwdata = 1'b1;
            end
        end
    end

    mhtq_heap_mem #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (w_hwe),
        .i_waddr (w_hwaddr),
        .i_wdata (w_hwdata),
        .i_raddr (w_hraddr),
        .o_rdata (w_hrdata)
    );

    mhtq_flag_mem #(
        .DEPTH (ID_COUNT),
        .AW    (FW)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (w_fwe),
        .i_waddr (w_fwaddr),
        .i_wdata (w_fwdata),
        .i_raddr (w_mod_tab[r_root.ident]),
        .o_rdata (w_frdata)
    );

    // Sequencer: state, heap bookkeeping and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ret       <= S_IDLE;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + FW'(1);
                    if (r_clr_addr == FW'(ID_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_key.expiry <= i_expire_time;
                        r_key.ident  <= i_timer_id;
                        r_now        <= i_now_time;
                        r_pos        <= AW'(r_count);
                        r_res_id     <= i_timer_id;
                        r_res_exp    <= i_expire_time;
                        r_res_last   <= 1'b1;
                        r_ret        <= S_IDLE;
                        case (i_kind)
                            mhtq_pkg::KIND_INSERT: begin
                                if (w_full) begin
                                    r_res_status <= mhtq_pkg::ST_REJECTED;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_res_status <= mhtq_pkg::ST_INSERTED;
                                    r_state      <= S_INS;
                                end
                            end
                            mhtq_pkg::KIND_CANCEL: begin
                                r_res_status <= mhtq_pkg::ST_CANCELLED;
                                r_res_exp    <= '0;
                                r_state      <= S_EMIT;
                            end
                            mhtq_pkg::KIND_TICK: begin
                                r_state <= S_TICK;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_INS: begin
                    if (r_pos == '0) begin
                        r_root  <= r_key;
                        r_count <= r_count + CW'(1);
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (w_par_le) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_EMIT;
                    end else begin
                        r_pos   <= w_parent;
                        r_state <= S_INS;
                    end
                end
                S_TICK: begin
                    if (r_count != '0 && r_root.expiry <= r_now) begin
                        r_state <= S_POP;
                    end else begin
                        r_res_status <= mhtq_pkg::ST_DONE;
                        r_res_id     <= '0;
                        r_res_exp    <= '0;
                        r_res_last   <= 1'b1;
                        r_ret        <= S_IDLE;
                        r_state      <= S_EMIT;
                    end
                end
                S_POP: begin
                    r_res_status <= w_frdata ? mhtq_pkg::ST_DROPPED : mhtq_pkg::ST_FIRED;
                    r_res_id     <= r_root.ident;
                    r_res_exp    <= r_root.expiry;
                    r_res_last   <= 1'b0;
                    r_ret        <= S_TICK;
                    r_key        <= w_hrdata;
                    r_pos        <= '0;
                    r_count      <= r_count - CW'(1);
                    r_state      <= (r_count == CW'(1)) ? S_EMIT : S_SD;
                end
                S_SD: begin
                    if (w_has_c1) begin
                        r_state <= S_SD_C1;
                    end else begin
                        if (r_pos == '0) begin
                            r_root <= r_key;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_SD_C1: begin
                    r_best     <= w_hrdata;
                    r_best_idx <= w_c1[AW-1:0];
                    r_state    <= w_has_c2 ? S_SD_C2 : S_SD_CMP;
                end
                S_SD_C2: begin
                    if (w_hrdata.expiry < r_best.expiry) begin
                        r_best     <= w_hrdata;
                        r_best_idx <= w_c2[AW-1:0];
                    end
                    r_state <= S_SD_CMP;
                end
                S_SD_CMP: begin
                    if (w_best_lt) begin
                        if (r_pos == '0) begin
                            r_root <= r_best;
                        end
                        r_pos   <= r_best_idx;
                        r_state <= S_SD;
                    end else begin
                        if (r_pos == '0) begin
                            r_root <= r_key;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_id     <= r_res_id;
                        r_out_exp    <= r_res_exp;
                        r_out_count  <= mhtq_pkg::COUNT_W'(r_count);
                        r_out_next   <= (r_count != '0) ? r_root.expiry : '0;
                        r_out_last   <= r_res_last;
                        r_state      <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_id      = r_out_id;
    assign o_out_expire  = r_out_exp;
    assign o_entry_count = r_out_count;
    assign o_next_expire = r_out_next;
    assign o_last        = r_out_last;

    // Heap fill never exceeds its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HEAP_DEPTH))
        else $error("heap count above depth");

    // A done result always closes its item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == mhtq_pkg::ST_DONE) |-> r_out_last)
        else $error("tick done result without last");

    // A pop result is never the last of its item
    a_pop_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == mhtq_pkg::ST_FIRED ||
                         r_out_status == mhtq_pkg::ST_DROPPED)) |-> !r_out_last)
        else $error("pop result marked last");

    // A stalled result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_status)))
        else $error("stalled result changed");

endmodule

[bench/min_heap_timer_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_timer_queue_tb
// Self-checking bench for the timer queue: a local heap model predicts each
// result item; random insert/cancel/tick traffic with stalls on both sides.
// ----------------------------------------------------------------------------
module min_heap_timer_queue_tb;

    localparam int DEPTH = mhtq_pkg::HEAP_DEPTH_DEF;
    localparam int NIDS  = mhtq_pkg::ID_COUNT_DEF;

    typedef struct packed {
        logic [mhtq_pkg::KIND_W-1:0] kind;
        logic [mhtq_pkg::ID_W-1:0]   id;
        logic [mhtq_pkg::TIME_W-1:0] exp;
        logic [mhtq_pkg::TIME_W-1:0] now;
    } t_cmd;

    typedef struct packed {
        logic [mhtq_pkg::STAT_W-1:0]  status;
        logic [mhtq_pkg::ID_W-1:0]    id;
        logic [mhtq_pkg::TIME_W-1:0]  exp;
        logic [mhtq_pkg::COUNT_W-1:0] count;
        logic [mhtq_pkg::TIME_W-1:0]  next;
        logic                         last;
    } t_res;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic [mhtq_pkg::KIND_W-1:0] kind = '0;
    logic [mhtq_pkg::ID_W-1:0] tid = '0;
    logic [mhtq_pkg::TIME_W-1:0] exp_t = '0;
    logic [mhtq_pkg::TIME_W-1:0] now_t = '0;
    logic in_stall, out_valid, last;
    logic [mhtq_pkg::STAT_W-1:0] status;
    logic [mhtq_pkg::ID_W-1:0] out_id;
    logic [mhtq_pkg::TIME_W-1:0] out_expire, next_expire;
    logic [mhtq_pkg::COUNT_W-1:0] entry_count;

    min_heap_timer_queue dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_timer_id(tid), .i_expire_time(exp_t), .i_now_time(now_t),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_out_id(out_id), .o_out_expire(out_expire),
        .o_entry_count(entry_count), .o_next_expire(next_expire), .o_last(last)
    );

    always #5 clk = ~clk;

    t_cmd pending_cmds[$];
    t_res expected_results[$];
    int   mismatches = 0;
    int   sent = 0;
    bit   hold_rx = 1'b0;
    bit   sender_busy = 1'b0;

    // heap mirror
    logic [mhtq_pkg::TIME_W-1:0] h_exp[DEPTH];
    logic [mhtq_pkg::ID_W-1:0]   h_id[DEPTH];
    int                          h_cnt = 0;
    bit                          cflag[NIDS];

    function automatic logic [mhtq_pkg::TIME_W-1:0] root_exp();
        return (h_cnt > 0) ? h_exp[0] : '0;
    endfunction

    function automatic void push_result(logic [mhtq_pkg::STAT_W-1:0] st,
                                        logic [mhtq_pkg::ID_W-1:0] id,
                                        logic [mhtq_pkg::TIME_W-1:0] e, logic fin);
        t_res r;
        r.status = st; r.id = id; r.exp = e;
        r.count = h_cnt[mhtq_pkg::COUNT_W-1:0]; r.next = root_exp(); r.last = fin;
        expected_results.push_back(r);
    endfunction

    // Predict results of one accepted item
    function automatic void predict_timer_op(t_cmd c);
        int pos, par, ch;
        logic [mhtq_pkg::TIME_W-1:0] ke;
        logic [mhtq_pkg::ID_W-1:0] ki, pid;
        logic [mhtq_pkg::TIME_W-1:0] pe;
        logic [mhtq_pkg::STAT_W-1:0] st;
        case (c.kind)
            mhtq_pkg::KIND_INSERT: begin
                if (h_cnt >= DEPTH) begin
                    push_result(mhtq_pkg::ST_REJECTED, c.id, c.exp, 1'b1);
                end else begin
                    cflag[c.id] = 1'b0;
                    pos = h_cnt;
                    h_cnt++;
                    while (pos > 0) begin
                        par = (pos - 1) / 2;
                        if (h_exp[par] <= c.exp) break;
                        h_exp[pos] = h_exp[par];
                        h_id[pos] = h_id[par];
                        pos = par;
                    end
                    h_exp[pos] = c.exp;
                    h_id[pos] = c.id;
                    push_result(mhtq_pkg::ST_INSERTED, c.id, c.exp, 1'b1);
                end
            end
            mhtq_pkg::KIND_CANCEL: begin
                cflag[c.id] = 1'b1;
                push_result(mhtq_pkg::ST_CANCELLED, c.id, '0, 1'b1);
            end
            mhtq_pkg::KIND_TICK: begin
                while (h_cnt > 0 && h_exp[0] <= c.now) begin
                    pid = h_id[0];
                    pe = h_exp[0];
                    st = cflag[pid] ? mhtq_pkg::ST_DROPPED : mhtq_pkg::ST_FIRED;
                    h_cnt--;
                    if (h_cnt > 0) begin
                        ke = h_exp[h_cnt];
                        ki = h_id[h_cnt];
                        pos = 0;
                        while (2 * pos + 1 < h_cnt) begin
                            ch = 2 * pos + 1;
                            if (ch + 1 < h_cnt && h_exp[ch + 1] < h_exp[ch]) ch++;
                            if (h_exp[ch] < ke) begin
                                h_exp[pos] = h_exp[ch];
                                h_id[pos] = h_id[ch];
                                pos = ch;
                            end else break;
                        end
                        h_exp[pos] = ke;
                        h_id[pos] = ki;
                    end
                    push_result(st, pid, pe, 1'b0);
                end
                push_result(mhtq_pkg::ST_DONE, '0, '0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: offer queued items, random gaps between them
    int tx_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_timer_op({kind, tid, exp_t, now_t});
                sent++;
            end
            if (in_valid && in_stall) begin
                // hold payload
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0 && !sender_busy) begin
                t_cmd c;
                c = pending_cmds.pop_front();
                kind <= c.kind; tid <= c.id; exp_t <= c.exp; now_t <= c.now;
                in_valid <= 1'b1;
                tx_gap <= gap_len();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    int rx_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                t_res got, want;
                got = {status, out_id, out_expire, entry_count, next_expire, last};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result differs: expected %h actual %h", want, got);
                    end
                end
            end
            if (hold_rx) begin
                out_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                rx_gap <= gap_len();
            end
        end
    end

    function automatic t_cmd mk(logic [mhtq_pkg::KIND_W-1:0] k,
                                logic [mhtq_pkg::ID_W-1:0] id,
                                logic [mhtq_pkg::TIME_W-1:0] e,
                                logic [mhtq_pkg::TIME_W-1:0] n);
        t_cmd c;
        c.kind = k; c.id = id; c.exp = e; c.now = n;
        return c;
    endfunction

    function automatic logic [mhtq_pkg::TIME_W-1:0] rnd_time(
        logic [mhtq_pkg::TIME_W-1:0] base);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom;
        if (r == 1) return '1 - $urandom_range(0, 3);
        return base + $urandom_range(0, 200);
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial begin
        logic [mhtq_pkg::TIME_W-1:0] clock_now;
        int r, n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, cancel before queued, unused kind, fill to full
        pending_cmds.push_back(mk(mhtq_pkg::KIND_TICK, 8'hFF, '1, '0));
        pending_cmds.push_back(mk(mhtq_pkg::KIND_CANCEL, 8'h00, '1, '1));
        pending_cmds.push_back(mk(mhtq_pkg::KIND_INSERT, 8'h00, '0, '1));
        pending_cmds.push_back(mk(mhtq_pkg::KIND_INSERT, 8'hFF, '1, '0));
        pending_cmds.push_back(mk(mhtq_pkg::KIND_CANCEL, 8'hFF, '0, '0));
        pending_cmds.push_back(mk(mhtq_pkg::KIND_NONE, 8'hA5, 32'h5A5A5A5A,
                                  32'hA5A5A5A5));
        pending_cmds.push_back(mk(mhtq_pkg::KIND_INSERT, 8'h55, 32'd100, '0));
        pending_cmds.push_back(mk(mhtq_pkg::KIND_TICK, '0, '0, 32'd100));
        pending_cmds.push_back(mk(mhtq_pkg::KIND_TICK, '0, '0, '1));
        for (int i = 0; i < DEPTH + 1; i++)
            pending_cmds.push_back(mk(mhtq_pkg::KIND_INSERT, i[7:0],
                                      32'(500 - i % 7), '0));
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_rx = 1'b1;
        pending_cmds.push_back(mk(mhtq_pkg::KIND_TICK, '0, '0, '1));
        for (int i = 0; i < 6; i++)
            pending_cmds.push_back(mk(mhtq_pkg::KIND_INSERT, 8'(i + 7), $urandom, '0));
        for (int i = 0; i < 400; i++) @(posedge clk);
        hold_rx = 1'b0;
        wait_drained();

        // random traffic around a moving clock
        clock_now = 32'd1000;
        n = 0;
        while (n < 420) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                pending_cmds.push_back(mk(mhtq_pkg::KIND_INSERT, 8'($urandom),
                                          rnd_time(clock_now), $urandom));
            else if (r < 70)
                pending_cmds.push_back(mk(mhtq_pkg::KIND_CANCEL, 8'($urandom),
                                          $urandom, $urandom));
            else if (r < 97) begin
                clock_now = clock_now + $urandom_range(0, 150);
                pending_cmds.push_back(mk(mhtq_pkg::KIND_TICK, 8'($urandom), $urandom,
                    ($urandom_range(0, 20) == 0) ? 32'($urandom) : clock_now));
            end else
                pending_cmds.push_back(mk(mhtq_pkg::KIND_NONE, 8'($urandom),
                                          $urandom, $urandom));
            if (r < 97) n++;
            if (n == 210 && r < 97) begin
                // sender pauses until everything has come back
                sender_busy = 1'b1;
                while (in_valid || expected_results.size() > 0) @(posedge clk);
                sender_busy = 1'b0;
                wait_drained();
            end
        end
        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("min_heap_timer_queue: match");
        else
            $display("min_heap_timer_queue: mismatch");
        $finish;
    end

    // Run limit
    initial begin
        #100ms;
        $display("min_heap_timer_queue: mismatch");
        $finish;
    end
endmodule
